### sv/lrs_pkg.sv
package lrs_pkg;

   // Default sample width and fixed-point fraction of the gain
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FRAC_BITS       = 16;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IN_LOW   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IN_HIGH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OUT_LOW  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OUT_HIGH = 2'd3;

   // Result status codes
   localparam logic [1:0] STAT_IN_RANGE  = 2'd0;
   localparam logic [1:0] STAT_CLAMP_HI  = 2'd1;
   localparam logic [1:0] STAT_CLAMP_LO  = 2'd2;
   localparam logic [1:0] STAT_ZERO_GAIN = 2'd3;

   typedef struct packed {
      logic busy;
      logic zero;
   } gain_status_type;

endpackage

### sv/lrs_gain_div.sv
module lrs_gain_div import lrs_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              restart,
   input  logic signed [SAMPLE_BITS-1:0]     in_low,
   input  logic signed [SAMPLE_BITS-1:0]     in_high,
   input  logic signed [SAMPLE_BITS-1:0]     out_low,
   input  logic signed [SAMPLE_BITS-1:0]     out_high,
   output logic [SAMPLE_BITS+FRAC_BITS-1:0]  gain,
   output gain_status_type                   status
);

   localparam int SB     = SAMPLE_BITS;
   localparam int PROD_W = SB + FRAC_BITS;
   localparam int NW     = SB + FRAC_BITS + 2;   // signed numerator
   localparam int NM     = NW - 1;               // numerator magnitude
   localparam int CNT_W  = $clog2(NM + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SPAN = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic signed [SB:0]  in_span_ff, in_span_in;
   logic signed [SB:0]  out_span_ff, out_span_in;
   logic [SB-1:0]       rem_ff, rem_in;
   logic [NM-1:0]       quo_ff, quo_in;
   logic [SB-1:0]       den_ff, den_in;
   logic                neg_ff, neg_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]   gain_ff, gain_in;
   logic                zero_ff, zero_in;

   logic signed [SB:0]  span_adj;
   logic signed [SB:0]  half_span;
   logic signed [NW-1:0] num;
   logic [NW-1:0]       num_abs;
   logic [SB:0]         den_abs;
   logic [SB:0]         trial;
   logic [SB:0]         trial_diff;
   logic [NM-1:0]       quo_neg;

   // Half the span, truncated toward zero, then the rounded numerator
   assign span_adj  = in_span_ff + {{SB{1'b0}}, in_span_ff[SB]};
   assign half_span = span_adj >>> 1;
   assign num = {{(NW-SB-1-FRAC_BITS){out_span_ff[SB]}}, out_span_ff, {FRAC_BITS{1'b0}}}
              + {{(NW-SB-1){half_span[SB]}}, half_span};
   assign num_abs = num[NW-1] ? (~num + NW'(1)) : num;
   assign den_abs = in_span_ff[SB] ? (~in_span_ff + (SB+1)'(1)) : in_span_ff;

   // One quotient bit a cycle
   assign trial      = {rem_ff, quo_ff[NM-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign quo_neg    = ~quo_ff + NM'(1);

   always_comb begin
      state_in    = state_ff;
      in_span_in  = in_span_ff;
      out_span_in = out_span_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      den_in      = den_ff;
      neg_in      = neg_ff;
      cnt_in      = cnt_ff;
      gain_in     = gain_ff;
      zero_in     = zero_ff;
      case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_SPAN: begin
            in_span_in  = {in_high[SB-1], in_high} - {in_low[SB-1], in_low};
            out_span_in = {out_high[SB-1], out_high} - {out_low[SB-1], out_low};
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            if (in_span_ff == '0) begin
               gain_in  = '0;
               zero_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rem_in   = '0;
               quo_in   = num_abs[NM-1:0];
               den_in   = den_abs[SB-1:0];
               neg_in   = num[NW-1] ^ in_span_ff[SB];
               cnt_in   = CNT_W'(NM);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!trial_diff[SB]) begin
               rem_in = trial_diff[SB-1:0];
               quo_in = {quo_ff[NM-2:0], 1'b1};
            end else begin
               rem_in = trial[SB-1:0];
               quo_in = {quo_ff[NM-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            gain_in  = neg_ff ? quo_neg[PROD_W-1:0] : quo_ff[PROD_W-1:0];
            zero_in  = (quo_ff == '0);
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A new write always restarts from the updated registers
      if (restart) begin
         state_in = ST_SPAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gain_ff  <= PROD_W'(1) << FRAC_BITS;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         gain_ff  <= gain_in;
         zero_ff  <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      in_span_ff  <= in_span_in;
      out_span_ff <= out_span_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
   end

   assign gain        = gain_ff;
   assign status.busy = (state_ff != ST_IDLE);
   assign status.zero = zero_ff;

endmodule

### sv/linear_range_scaler.sv
// Channel   Ports                                          Handshake
// request   start, busy, req_sample                        taken when start && !busy
// result    rsp_valid, rsp_scaled_value, rsp_sat_status    one-cycle strobe, no stall
// config    csr_wr_en, csr_index, csr_wdata                taken when csr_wr_en
//
// One sample is taken per cycle while busy is low; its result passes the input register,
// clamp, multiply and offset registers in that order before its result strobe rises.
// A config write starts the gain divider, which retires one quotient bit a cycle: busy
// then stays high through the span, load, divide and done states, or only through the
// span and load states for a zero input span. After reset the ranges are full scale and
// the gain is 1.0, busy low. The result side cannot stall, so the pipeline never holds.
module linear_range_scaler import lrs_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS-1:0] rsp_scaled_value,
   output logic [1:0]                    rsp_sat_status,
   input  logic                          csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [SAMPLE_BITS-1:0]        csr_wdata
);

   localparam int SB     = SAMPLE_BITS;
   localparam int PROD_W = SB + FRAC_BITS;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

   logic signed [SB-1:0] in_low_ff, in_low_in;
   logic signed [SB-1:0] in_high_ff, in_high_in;
   logic signed [SB-1:0] out_low_ff, out_low_in;
   logic signed [SB-1:0] out_high_ff, out_high_in;

   logic [PROD_W-1:0]    gain;
   gain_status_type      gain_status;

   logic                 v0_ff, v1_ff, v2_ff, v3_ff;
   logic signed [SB-1:0] sample_ff;
   logic signed [SB:0]   diff_ff, diff_in;
   logic [1:0]           stat1_ff, stat1_in;
   logic [1:0]           stat2_ff;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [SB-1:0] value_ff, value_in;
   logic [1:0]           stat3_ff, stat3_in;

   logic signed [SB-1:0] clamped;
   logic [PROD_W-1:0]    diff_ext;
   logic                 accept;

   always_comb begin
      in_low_in   = in_low_ff;
      in_high_in  = in_high_ff;
      out_low_in  = out_low_ff;
      out_high_in = out_high_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_IN_LOW:   in_low_in   = csr_wdata;
            REG_IN_HIGH:  in_high_in  = csr_wdata;
            REG_OUT_LOW:  out_low_in  = csr_wdata;
            REG_OUT_HIGH: out_high_in = csr_wdata;
            default: begin
               in_low_in = in_low_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_low_ff   <= {1'b1, {(SB-1){1'b0}}};
         in_high_ff  <= {1'b0, {(SB-1){1'b1}}};
         out_low_ff  <= {1'b1, {(SB-1){1'b0}}};
         out_high_ff <= {1'b0, {(SB-1){1'b1}}};
      end else begin
         in_low_ff   <= in_low_in;
         in_high_ff  <= in_high_in;
         out_low_ff  <= out_low_in;
         out_high_ff <= out_high_in;
      end
   end

   lrs_gain_div #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_gain_div (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_wr_en),
      .in_low   (in_low_ff),
      .in_high  (in_high_ff),
      .out_low  (out_low_ff),
      .out_high (out_high_ff),
      .gain     (gain),
      .status   (gain_status)
   );

   assign busy   = gain_status.busy;
   assign accept = start && !busy;

   // Clamp; an inverted range clamps high first
   always_comb begin
      clamped  = sample_ff;
      stat1_in = STAT_IN_RANGE;
      if (sample_ff > in_high_ff) begin
         clamped  = in_high_ff;
         stat1_in = STAT_CLAMP_HI;
      end else if (sample_ff < in_low_ff) begin
         clamped  = in_low_ff;
         stat1_in = STAT_CLAMP_LO;
      end
      diff_in = {clamped[SB-1], clamped} - {in_low_ff[SB-1], in_low_ff};
   end

   // Only the low PROD_W bits of the product reach the output
   assign diff_ext = {{(PROD_W-SB-1){diff_ff[SB]}}, diff_ff};
   assign prod_in  = gain * diff_ext + ROUND_HALF;

   always_comb begin
      if (gain_status.zero) begin
         value_in = '0;
         stat3_in = STAT_ZERO_GAIN;
      end else begin
         value_in = prod_ff[PROD_W-1:FRAC_BITS] + out_low_ff;
         stat3_in = stat2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= req_sample;
      diff_ff   <= diff_in;
      stat1_ff  <= stat1_in;
      prod_ff   <= prod_in;
      stat2_ff  <= stat1_ff;
      value_ff  <= value_in;
      stat3_ff  <= stat3_in;
   end

   assign rsp_valid        = v3_ff;
   assign rsp_scaled_value = value_ff;
   assign rsp_sat_status   = stat3_ff;

endmodule

### tb/tb_linear_range_scaler.sv
module tb_linear_range_scaler;
   import lrs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW          = SAMPLE_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PIPE_DEPTH  = 8;
   localparam int RAND_PHASES = 20;
   localparam int PHASE_ITEMS = 52;

   typedef struct {
      logic signed [SW-1:0] value;
      logic [1:0]           status;
   } scaled_item_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic signed [SW-1:0] req_sample = '0;
   logic                 rsp_valid;
   logic signed [SW-1:0] rsp_scaled_value;
   logic [1:0]           rsp_sat_status;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_IN_LOW;
   logic [SW-1:0]        csr_wdata = '0;

   // range registers and gain as the block should hold them
   longint range_in_low;
   longint range_in_high;
   longint range_out_low;
   longint range_out_high;
   longint range_gain;

   scaled_item_type pending_scaled[$];
   int           mismatches = 0;
   int           cycle_count = 0;
   bit           no_idle = 0;

   linear_range_scaler #(.SAMPLE_BITS(SW)) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_sat_status   (rsp_sat_status),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic void derive_gain();
      longint span;
      longint num;
      span = range_in_high - range_in_low;
      if (span == 0) begin
         range_gain = 0;
      end else begin
         num = (range_out_high - range_out_low) * (longint'(1) << FRAC_BITS);
         num = num + span / 2;
         range_gain = num / span;
      end
   endfunction

   function automatic scaled_item_type scale_sample(input logic signed [SW-1:0] s);
      scaled_item_type r;
      longint       x;
      logic [63:0]  acc;
      x = s;
      if (range_gain == 0) begin
         r.value  = '0;
         r.status = STAT_ZERO_GAIN;
         return r;
      end
      if (x > range_in_high) begin
         x = range_in_high;
         r.status = STAT_CLAMP_HI;
      end else if (x < range_in_low) begin
         x = range_in_low;
         r.status = STAT_CLAMP_LO;
      end else begin
         r.status = STAT_IN_RANGE;
      end
      acc = range_gain * (x - range_in_low);
      acc = acc + (64'd1 << (FRAC_BITS - 1));
      acc = acc >> FRAC_BITS;
      acc = acc + range_out_low;
      r.value = acc[SW-1:0];
      return r;
   endfunction

   // compare every strobed result with the oldest prediction
   always @(posedge clock) begin
      scaled_item_type exp_item;
      if (!reset && rsp_valid) begin
         if (pending_scaled.size() == 0) begin
            $error("unexpected result: scaled_value %0d sat_status %0d",
                   rsp_scaled_value, rsp_sat_status);
            mismatches++;
         end else begin
            exp_item = pending_scaled.pop_front();
            if (rsp_scaled_value !== exp_item.value) begin
               $error("scaled_value: expected %0d, got %0d", exp_item.value,
                      rsp_scaled_value);
               mismatches++;
            end
            if (rsp_sat_status !== exp_item.status) begin
               $error("sat_status: expected %0d, got %0d", exp_item.status,
                      rsp_sat_status);
               mismatches++;
            end
         end
      end
   end

   task automatic send_sample(input logic signed [SW-1:0] s);
      @(negedge clock);
      start      <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (busy);
      pending_scaled.push_back(scale_sample(s));
   endtask

   task automatic idle_gap();
      int roll;
      int len;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 70) return;
      len = (roll < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      @(negedge clock);
      start <= 1'b0;
      repeat (len - 1) @(negedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_scaled.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [SW-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_IN_LOW:   range_in_low   = longint'($signed(value));
         REG_IN_HIGH:  range_in_high  = longint'($signed(value));
         REG_OUT_LOW:  range_out_low  = longint'($signed(value));
         REG_OUT_HIGH: range_out_high = longint'($signed(value));
         default: ;
      endcase
      derive_gain();
      // hold until the gain divider has finished
      @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic set_ranges(input logic [SW-1:0] il, input logic [SW-1:0] ih,
                             input logic [SW-1:0] ol, input logic [SW-1:0] oh);
      drain_results();
      csr_write(REG_IN_LOW, il);
      csr_write(REG_IN_HIGH, ih);
      csr_write(REG_OUT_LOW, ol);
      csr_write(REG_OUT_HIGH, oh);
   endtask

   task automatic test_reset_identity();
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      send_sample(16'sh0000);
      send_sample(16'shffff);
      send_sample(16'sh5555);
   endtask

   task automatic test_directed_ranges();
      // narrow range with clamps on both sides
      set_ranges(-16'sd100, 16'sd100, -16'sd1000, 16'sd1000);
      send_sample(-16'sd101);
      send_sample(16'sd100);
      send_sample(16'sd101);
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      // inverted input range
      set_ranges(16'sd100, -16'sd100, -16'sd1000, 16'sd1000);
      send_sample(16'sd200);
      send_sample(16'sd0);
      send_sample(-16'sd200);
      // zero input span
      set_ranges(16'sd5, 16'sd5, -16'sd1000, 16'sd1000);
      send_sample(16'sd5);
      send_sample(16'sh8000);
      // flat output range
      set_ranges(-16'sd100, 16'sd100, 16'sd7, 16'sd7);
      send_sample(16'sd0);
      send_sample(16'sh7fff);
      // falling output range, negative gain
      set_ranges(16'sd0, 16'sd1000, 16'sh7fff, 16'sh8000);
      send_sample(16'sd0);
      send_sample(16'sd1000);
      send_sample(16'sd500);
      // inverted full-scale input range
      set_ranges(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
      send_sample(16'sd0);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
   endtask

   function automatic logic [SW-1:0] pick_extreme();
      return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
   endfunction

   task automatic random_config();
      logic [SW-1:0] il;
      logic [SW-1:0] ih;
      logic [SW-1:0] ol;
      logic [SW-1:0] oh;
      il = SW'($urandom);
      ih = SW'($urandom);
      ol = SW'($urandom);
      oh = SW'($urandom);
      case ($urandom_range(0, 5))
         0: begin
            il = pick_extreme();
            ih = pick_extreme();
            ol = pick_extreme();
            oh = pick_extreme();
         end
         1: ih = il + SW'($urandom_range(1, 64));
         2: ih = il;
         3: oh = ol;
         4: ih = il - SW'($urandom_range(1, 64));
         default: ;
      endcase
      set_ranges(il, ih, ol, oh);
   endtask

   function automatic logic [SW-1:0] random_sample();
      longint edge_val;
      if ($urandom_range(0, 9) < 6) return SW'($urandom);
      edge_val = $urandom_range(0, 1) ? range_in_low : range_in_high;
      edge_val = edge_val + $urandom_range(0, 8) - 4;
      return edge_val[SW-1:0];
   endfunction

   task automatic test_random_phases();
      int pause_at;
      for (int p = 0; p < RAND_PHASES; p++) begin
         random_config();
         no_idle  = ($urandom_range(0, 3) == 0);
         // first phase always pauses to let every result come back
         pause_at = (p == 0 || $urandom_range(0, 3) == 0) ?
                    $urandom_range(1, PHASE_ITEMS - 1) : -1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == pause_at) drain_results();
            send_sample(random_sample());
            idle_gap();
         end
      end
      no_idle = 0;
   endtask

   initial begin
      range_in_low   = -32768;
      range_in_high  = 32767;
      range_out_low  = -32768;
      range_out_high = 32767;
      derive_gain();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_identity();
      test_directed_ranges();
      test_random_phases();

      drain_results();
      repeat (PIPE_DEPTH) @(negedge clock);
      if (pending_scaled.size() != 0) begin
         $error("%0d expected results never arrived", pending_scaled.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
sv/lrs_pkg.sv
sv/lrs_gain_div.sv
sv/linear_range_scaler.sv
tb/tb_linear_range_scaler.sv
